// File: src/bmp24_stream_pixel_extractor_defines.svh
// ----------------------------------------------------------------------------
// bmp24 stream pixel extractor assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BMP24_STREAM_PIXEL_EXTRACTOR_DEFINES_SVH
`define BMP24_STREAM_PIXEL_EXTRACTOR_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BMPX_ASSERT_NOW(name, clk_s, rst_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define BMPX_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/bmpx_pkg.sv
// ----------------------------------------------------------------------------
// bmpx_pkg
// types and constants shared by the bmp24 pixel extractor modules
// ----------------------------------------------------------------------------
`default_nettype none

package bmpx_pkg;

	// header layout of a 24-bit bitmap file
	localparam int unsigned HEADER_BYTES = 54;
	localparam int unsigned OFFSET_POS   = 10;
	localparam int unsigned OFFSET_BYTES = 4;
	localparam int unsigned WIDTH_POS    = 18;
	localparam int unsigned HEIGHT_POS   = 22;

	// defaults for the top level parameters
	localparam int unsigned DEF_DIM_BITS    = 16;
	localparam int unsigned DEF_QUEUE_DEPTH = 2;

	// field widths on the ports
	localparam int unsigned COLOR_W = 8;
	localparam int unsigned COORD_W = 16;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_SKIP   = 2'd1,
		PH_PIXELS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		CH_BLUE  = 2'd0,
		CH_GREEN = 2'd1,
		CH_RED   = 2'd2
	} chan_t;

	typedef struct packed {
		logic               last_pixel;
		logic [COORD_W-1:0] stored_row;
		logic [COORD_W-1:0] column;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} pix_t;

endpackage

`default_nettype wire

// File: src/bmpx_parser.sv
// ----------------------------------------------------------------------------
// bmpx_parser
// front end: walks the file header, skips to the pixel data and builds pixels
// ----------------------------------------------------------------------------
`default_nettype none

module bmpx_parser
	import bmpx_pkg::*;
#(
	parameter int unsigned DIM_BITS = DEF_DIM_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_take,
	input  logic [7:0] in_byte,
	input  logic       in_first,
	output logic       pix_valid,
	output pix_t       pix
);

	logic [31:0]         pos_q, pos_c, pos_n;
	phase_t              phase_q, phase_c, phase_n;
	logic [31:0]         offset_q, offset_c, offset_n;
	logic [DIM_BITS-1:0] width_q, width_c, width_n;
	logic [DIM_BITS-1:0] height_q, height_c, height_n;
	logic [DIM_BITS-1:0] col_q, col_c, col_n;
	logic [DIM_BITS-1:0] row_q, row_c, row_n;
	chan_t               chan_q, chan_c, chan_n;
	logic [1:0]          pad_q, pad_c, pad_n;
	logic [7:0]          blue_q, blue_n;
	logic [7:0]          green_q, green_n;

	logic                do_pixel;
	logic                row_end;
	logic                last;
	logic [1:0]          lane;
	logic [15:0]         w_ext;
	logic [15:0]         h_ext;

	always_comb begin
		// a file start restarts the parse on this very byte
		if (in_first) begin
			pos_c    = '0;
			phase_c  = PH_HEADER;
			offset_c = '0;
			width_c  = '0;
			height_c = '0;
			col_c    = '0;
			row_c    = '0;
			chan_c   = CH_BLUE;
			pad_c    = '0;
		end else begin
			pos_c    = pos_q;
			phase_c  = phase_q;
			offset_c = offset_q;
			width_c  = width_q;
			height_c = height_q;
			col_c    = col_q;
			row_c    = row_q;
			chan_c   = chan_q;
			pad_c    = pad_q;
		end
	end

	assign lane  = pos_c[1:0] - 2'(OFFSET_POS);
	assign w_ext = 16'(width_c);
	assign h_ext = 16'(height_c);

	always_comb begin
		pos_n     = pos_c;
		phase_n   = phase_c;
		offset_n  = offset_c;
		width_n   = width_c;
		height_n  = height_c;
		col_n     = col_c;
		row_n     = row_c;
		chan_n    = chan_c;
		pad_n     = pad_c;
		blue_n    = blue_q;
		green_n   = green_q;
		do_pixel  = 1'b0;
		pix_valid = 1'b0;
		row_end   = (col_c == width_c - DIM_BITS'(1));
		last      = row_end && (row_c == height_c - DIM_BITS'(1));

		pix.red        = in_byte;
		pix.green      = green_q;
		pix.blue       = blue_q;
		pix.column     = 16'(col_c);
		pix.stored_row = 16'(row_c);
		pix.last_pixel = last;

		unique case (phase_c)
			PH_HEADER: begin
				if (pos_c >= 32'(OFFSET_POS) && pos_c < 32'(OFFSET_POS + OFFSET_BYTES)) begin
					offset_n[{lane, 3'b000} +: 8] = in_byte;
				end else if (pos_c == 32'(WIDTH_POS)) begin
					width_n = DIM_BITS'({w_ext[15:8], in_byte});
				end else if (pos_c == 32'(WIDTH_POS + 1)) begin
					width_n = DIM_BITS'({in_byte, w_ext[7:0]});
				end else if (pos_c == 32'(HEIGHT_POS)) begin
					height_n = DIM_BITS'({h_ext[15:8], in_byte});
				end else if (pos_c == 32'(HEIGHT_POS + 1)) begin
					height_n = DIM_BITS'({in_byte, h_ext[7:0]});
				end
				pos_n = pos_c + 32'd1;
				if (pos_c == 32'(HEADER_BYTES - 1)) begin
					if (width_n == '0 || height_n == '0) begin
						phase_n = PH_DONE;
					end else if (offset_n <= 32'(HEADER_BYTES)) begin
						phase_n = PH_PIXELS;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (pos_c != offset_c) begin
					pos_n = pos_c + 32'd1;
				end else begin
					phase_n  = PH_PIXELS;
					do_pixel = 1'b1;
				end
			end
			PH_PIXELS: begin
				do_pixel = 1'b1;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (do_pixel) begin
			if (pad_c != 2'd0) begin
				pad_n = pad_c - 2'd1;
			end else begin
				case (chan_c)
					CH_BLUE: begin
						blue_n = in_byte;
						chan_n = CH_GREEN;
					end
					CH_GREEN: begin
						green_n = in_byte;
						chan_n  = CH_RED;
					end
					default: begin
						pix_valid = 1'b1;
						chan_n    = CH_BLUE;
						if (last) begin
							phase_n = PH_DONE;
						end else if (row_end) begin
							col_n = '0;
							row_n = row_c + DIM_BITS'(1);
							pad_n = width_c[1:0];
						end else begin
							col_n = col_c + DIM_BITS'(1);
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= PH_HEADER;
			offset_q <= '0;
			width_q  <= '0;
			height_q <= '0;
			col_q    <= '0;
			row_q    <= '0;
			chan_q   <= CH_BLUE;
			pad_q    <= '0;
		end else if (in_take) begin
			pos_q    <= pos_n;
			phase_q  <= phase_n;
			offset_q <= offset_n;
			width_q  <= width_n;
			height_q <= height_n;
			col_q    <= col_n;
			row_q    <= row_n;
			chan_q   <= chan_n;
			pad_q    <= pad_n;
		end
	end

	// partial pixel components, always written before they are read
	always_ff @(posedge clk) begin
		if (in_take) begin
			blue_q  <= blue_n;
			green_q <= green_n;
		end
	end

endmodule

`default_nettype wire

// File: src/bmpx_fifo.sv
// ----------------------------------------------------------------------------
// bmpx_fifo
// short pixel queue between the parser and the output stage
// ----------------------------------------------------------------------------
`default_nettype none

module bmpx_fifo
	import bmpx_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pix_t push_data,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output pix_t head
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	pix_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: src/bmpx_emit.sv
// ----------------------------------------------------------------------------
// bmpx_emit
// back end: output register that presents one pixel beat to the stream
// ----------------------------------------------------------------------------
`default_nettype none

module bmpx_emit
	import bmpx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  pix_t        head,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,
	output logic        m_axis_tlast
);

	logic valid_q;
	pix_t data_q;

	assign pop = head_valid && (!valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= head;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {data_q.stored_row, data_q.column, data_q.blue, data_q.green,
		data_q.red};
	assign m_axis_tlast  = data_q.last_pixel;

endmodule

`default_nettype wire

// File: src/bmp24_stream_pixel_extractor.sv
// ----------------------------------------------------------------------------
// bmp24_stream_pixel_extractor
// pulls 24-bit pixels with their coordinates out of a bitmap byte stream
// ----------------------------------------------------------------------------
//
// channel   dir  beat contents
// s_axis    in   tdata: file byte; tuser: file start
// m_axis    out  tdata: red, green, blue, column, stored row; tlast: last pixel
//
// one file byte is taken every cycle while s_axis_tready is high
// a pixel enters the pixel queue when its red byte is taken, then reaches m_axis via the output register
// s_axis_tready falls only when the pixel queue is full behind a stalled output
// arst_n clears the parser so the first byte after reset is header byte 0
// no clearing pass: the block takes bytes from the first cycle after reset
//
`default_nettype none

module bmp24_stream_pixel_extractor
	import bmpx_pkg::*;
#(
	parameter int unsigned DIM_BITS    = DEF_DIM_BITS,    // 8 to 16
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH  // 2 or more
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue,
	                                    // [39:24] column, [55:40] stored_row
	output logic        m_axis_tlast    // last_pixel
);

	logic in_take;     // byte beat accepted this cycle
	logic pix_valid;   // presented byte completes a pixel
	pix_t pix;
	logic q_full;
	logic q_pop;
	logic q_valid;
	pix_t q_head;

	// space for one more pixel is all the front end needs
	assign s_axis_tready = !q_full;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// front: header walk, offset skip, pixel assembly
	bmpx_parser #(
		.DIM_BITS (DIM_BITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_take   (in_take),
		.in_byte   (s_axis_tdata),
		.in_first  (s_axis_tuser),
		.pix_valid (pix_valid),
		.pix       (pix)
	);

	// queue decouples byte intake from output stalls
	bmpx_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_take && pix_valid),
		.push_data  (pix),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	// back: output register toward the sink
	bmpx_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_valid),
		.head          (q_head),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// File: src/bmpx_checker.sv
// ----------------------------------------------------------------------------
// bmpx_checker
// port-level checks on the bmp24 pixel extractor, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bmp24_stream_pixel_extractor_defines.svh"

module bmpx_checker #(
	parameter int unsigned DIM_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [7:0]  s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [55:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic [15:0] col_hi;
	logic [15:0] row_hi;
	logic        unused_in;

	assign col_hi    = m_axis_tdata[39:24] >> DIM_BITS;
	assign row_hi    = m_axis_tdata[55:40] >> DIM_BITS;
	assign unused_in = s_axis_tvalid ^ s_axis_tuser ^ (^s_axis_tdata);

	// a stalled pixel beat keeps its contents
	`BMPX_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled pixel beat changed")

	// intake only closes while the output side is stalled
	`BMPX_ASSERT_NEXT(a_stall_onset, clk, arst_n, s_axis_tready && !(m_axis_tvalid && !m_axis_tready), s_axis_tready, "byte stall without output stall")

	// intake only backs up behind a waiting pixel
	`BMPX_ASSERT_NOW(a_stall_cause, clk, arst_n, !s_axis_tready, m_axis_tvalid, "byte stall without pending pixel")

	// coordinates stay within the configured dimension width
	`BMPX_ASSERT_NOW(a_coord_range, clk, arst_n, m_axis_tvalid, col_hi == 16'd0 && row_hi == 16'd0 && (unused_in || !unused_in), "coordinate above dimension width")

endmodule

bind bmp24_stream_pixel_extractor bmpx_checker #(
	.DIM_BITS (DIM_BITS)
) u_bmpx_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
